/* src/trs_pkg.sv */
// ---------------------------------------------------------------------------
// trs_pkg - shared types and constants for the triangle rate scanner
// Command and result payloads, queue entry, sequencer states.
// ---------------------------------------------------------------------------
package trs_pkg;

	localparam int          SYMBOLS_DEF = 8;
	localparam int          QDEPTH      = 2;
	localparam logic [19:0] PPM_RESET   = 20'd500;
	localparam logic [63:0] PPM_SCALE   = 64'd1000000;
	// ceil(2^72 / 15625): x * 2^32 / 1e6 == (x * PPM_RECIP) >> 46 for x < 2^32
	localparam logic [63:0] PPM_RECIP   = 64'h0431_BDE8_2D7B_634E;

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_SCAN   = 1'b1;

	typedef struct packed {
		logic        action;
		logic [2:0]  base_sym;
		logic [2:0]  quote_sym;
		logic [31:0] bid_price;
		logic [31:0] ask_price;
	} cmd_t;

	typedef struct packed {
		logic        hit;
		logic [2:0]  first_sym;
		logic [2:0]  second_sym;
		logic [2:0]  third_sym;
		logic [63:0] factor;
		logic        last;
	} result_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_UPDATE,
		OP_SCAN
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [2:0]  base_sym;
		logic [2:0]  quote_sym;
		logic [31:0] bid_price;
		logic [31:0] ask_price;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} qh_t;

	typedef enum logic [1:0] {
		DIV_FWD,
		DIV_REV,
		DIV_THR,
		DIV_TRI
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_WRITE,
		ST_SCAN,
		ST_RD_BC,
		ST_RD_CA,
		ST_CAP,
		ST_MUL,
		ST_MRES,
		ST_CMP,
		ST_FLUSH
	} state_t;

endpackage

/* src/triangle_rate_scanner.sv */
// Update: reciprocal multiply plus write for a nonzero bid, 64-step divider plus write
// for a nonzero ask, both in turn when both are nonzero; nothing is written with both zero.
// Scan: threshold multiply, then each triple is skipped or, if active, handled by three
// table reads and sequential 32x32 multiplies; a flush transfer closes the scan.
// Results leave one per strobe; the receiver cannot stall. A two-entry command queue
// lets start be taken while the executor works. Reset clears valid bits, flags, queue.
// ---------------------------------------------------------------------------
// triangle_rate_scanner - triangular rate product scanner
// Keeps a Q32.32 rate table and reports triples whose rate product beats
// one plus a programmable return.
// ---------------------------------------------------------------------------
module triangle_rate_scanner #(
	parameter int SYMBOLS = trs_pkg::SYMBOLS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  trs_pkg::cmd_t    cmd,
	output logic             busy,
	input  logic             cfg_we,
	input  logic [19:0]      cfg_wdata,
	output trs_pkg::result_t result,
	output logic             strobe
);

	logic [19:0]  ppm_q;
	trs_pkg::qh_t qh;
	logic         pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppm_q <= trs_pkg::PPM_RESET;
		end else if (cfg_we) begin
			ppm_q <= cfg_wdata;
		end
	end

	trs_front #(.SYMBOLS(SYMBOLS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.pop    (pop),
		.qh     (qh)
	);

	trs_back #(.SYMBOLS(SYMBOLS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.qh             (qh),
		.pop            (pop),
		.min_return_ppm (ppm_q),
		.result         (result),
		.strobe         (strobe)
	);

	// no-hit transfer closes the scan and carries zeros
	a_nohit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.hit |-> result.last && result.factor == '0 &&
		result.first_sym == '0 && result.third_sym == '0)
		else $error("no-hit result malformed");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.hit |->
		result.first_sym < result.second_sym && result.second_sym < result.third_sym)
		else $error("hit triple not ascending");

	a_factor: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.hit |-> result.factor[63:32] != '0)
		else $error("hit factor not above one");

endmodule

/* src/trs_ram.sv */
// ---------------------------------------------------------------------------
// trs_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module trs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* src/trs_front.sv */
// ---------------------------------------------------------------------------
// trs_front - command intake
// Classifies commands and holds them in a short queue for the executor.
// ---------------------------------------------------------------------------
module trs_front #(
	parameter int SYMBOLS = trs_pkg::SYMBOLS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  trs_pkg::cmd_t cmd,
	output logic          busy,
	input  logic          pop,
	output trs_pkg::qh_t  qh
);

	localparam int QAW = (trs_pkg::QDEPTH > 1) ? $clog2(trs_pkg::QDEPTH) : 1;
	localparam int CW  = $clog2(trs_pkg::QDEPTH + 1);

	trs_pkg::op_t   mem_q [trs_pkg::QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [CW-1:0]  cnt_q;
	trs_pkg::op_t   op_in;
	logic           push;

	always_comb begin
		op_in.base_sym  = cmd.base_sym;
		op_in.quote_sym = cmd.quote_sym;
		op_in.bid_price = cmd.bid_price;
		op_in.ask_price = cmd.ask_price;
		if (cmd.action == trs_pkg::ACT_SCAN) begin
			op_in.kind = trs_pkg::OP_SCAN;
		end else if (32'(cmd.base_sym) >= 32'(SYMBOLS) ||
		             32'(cmd.quote_sym) >= 32'(SYMBOLS)) begin
			op_in.kind = trs_pkg::OP_NOP;
		end else begin
			op_in.kind = trs_pkg::OP_UPDATE;
		end
	end

	assign busy     = (cnt_q == CW'(trs_pkg::QDEPTH));
	assign push     = start && !busy;
	assign qh.valid = (cnt_q != '0);
	assign qh.op    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QAW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QAW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* src/trs_back.sv */
// ---------------------------------------------------------------------------
// trs_back - command executor
// Radix-2 divider for reverse rates, reciprocal multiply for forward rates
// and threshold, rate table RAM, triple walk with a sequential 32x32
// multiplier, and the result register.
// ---------------------------------------------------------------------------
module trs_back #(
	parameter int SYMBOLS = trs_pkg::SYMBOLS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  trs_pkg::qh_t     qh,
	output logic             pop,
	input  logic [19:0]      min_return_ppm,
	output trs_pkg::result_t result,
	output logic             strobe
);

	localparam int SW    = $clog2(SYMBOLS);
	localparam int DEPTH = SYMBOLS * SYMBOLS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [SW-1:0] C_END = SW'(SYMBOLS - 1);
	localparam logic [SW-1:0] B_END = SW'(SYMBOLS - 2);
	localparam logic [SW-1:0] A_END = SW'(SYMBOLS - 3);

	function automatic logic [AW-1:0] ent(input logic [SW-1:0] r, input logic [SW-1:0] c);
		return AW'(r) * AW'(SYMBOLS) + AW'(c);
	endfunction

	trs_pkg::state_t   state_q, state_d;
	trs_pkg::op_t      op_q;
	trs_pkg::div_sel_t dsel_q;
	trs_pkg::result_t  result_q;

	logic [63:0]  dvd_q, quo_q, thr_q;
	logic [31:0]  rem_q, dvs_q;
	logic [5:0]   dcnt_q;
	logic [SYMBOLS-1:0] act_q;
	logic [DEPTH-1:0]   vld_q;
	logic [SW-1:0] a_q, b_q, c_q, na, nb, nc;
	logic          more;
	logic          rdv_q;
	logic [63:0]   rab_q, rbc_q, rca_q, rdval;
	logic [63:0]   mx_q, my_q, pp_s1, f_q;
	logic [1:0]    pk_s1;
	logic [2:0]    mk_q;
	logic [127:0]  acc_q;
	logic          mph_q, ovf;
	logic          pend_q, strobe_q;
	logic [2:0]    pa_q, pb_q, pc_q;
	logic [63:0]   pf_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [63:0]   rdata;

	logic [32:0]   dr;
	logic          dge;
	logic [31:0]   rnext;
	logic [63:0]   qnext;
	logic [31:0]   xp, yp;
	logic          all_act, hit_now;

	trs_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (quo_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// restoring divider step
	assign dr    = {rem_q, dvd_q[63]};
	assign dge   = (dr >= {1'b0, dvs_q});
	assign rnext = dge ? 32'(dr - {1'b0, dvs_q}) : dr[31:0];
	assign qnext = {quo_q[62:0], dge};

	assign xp      = mk_q[1] ? mx_q[63:32] : mx_q[31:0];
	assign yp      = mk_q[0] ? my_q[63:32] : my_q[31:0];
	assign ovf     = |acc_q[127:96];
	assign rdval   = rdv_q ? rdata : '0;
	assign all_act = act_q[a_q] && act_q[b_q] && act_q[c_q];
	assign hit_now = (f_q > thr_q);

	// next triple a<b<c in ascending order
	always_comb begin
		more = 1'b1;
		na   = a_q;
		nb   = b_q;
		nc   = c_q;
		if (c_q != C_END) begin
			nc = c_q + SW'(1);
		end else if (b_q != B_END) begin
			nb = b_q + SW'(1);
			nc = b_q + SW'(2);
		end else if (a_q != A_END) begin
			na = a_q + SW'(1);
			nb = a_q + SW'(2);
			nc = a_q + SW'(3);
		end else begin
			more = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		we      = 1'b0;
		waddr   = ent(SW'(op_q.base_sym), SW'(op_q.quote_sym));
		raddr   = ent(a_q, b_q);
		unique case (state_q)
			trs_pkg::ST_IDLE: begin
				if (qh.valid) begin
					pop = 1'b1;
					unique case (qh.op.kind)
						trs_pkg::OP_UPDATE: begin
							if (qh.op.bid_price != '0) begin
								state_d = trs_pkg::ST_MUL;
							end else if (qh.op.ask_price != '0) begin
								state_d = trs_pkg::ST_DIV;
							end
						end
						trs_pkg::OP_SCAN: state_d = trs_pkg::ST_MUL;
						default: state_d = trs_pkg::ST_IDLE;
					endcase
				end
			end
			trs_pkg::ST_DIV: begin
				if (dcnt_q == 6'd63) begin
					state_d = trs_pkg::ST_WRITE;
				end
			end
			trs_pkg::ST_WRITE: begin
				we = 1'b1;
				if (dsel_q != trs_pkg::DIV_FWD) begin
					waddr = ent(SW'(op_q.quote_sym), SW'(op_q.base_sym));
				end
				state_d = (dsel_q == trs_pkg::DIV_FWD && op_q.ask_price != '0)
				          ? trs_pkg::ST_DIV : trs_pkg::ST_IDLE;
			end
			trs_pkg::ST_SCAN: begin
				if (all_act) begin
					state_d = trs_pkg::ST_RD_BC;
				end else if (!more) begin
					state_d = trs_pkg::ST_FLUSH;
				end
			end
			trs_pkg::ST_RD_BC: begin
				raddr   = ent(b_q, c_q);
				state_d = trs_pkg::ST_RD_CA;
			end
			trs_pkg::ST_RD_CA: begin
				raddr   = ent(c_q, a_q);
				state_d = trs_pkg::ST_CAP;
			end
			trs_pkg::ST_CAP: state_d = trs_pkg::ST_MUL;
			trs_pkg::ST_MUL: begin
				if (mk_q == 3'd4) begin
					state_d = trs_pkg::ST_MRES;
				end
			end
			trs_pkg::ST_MRES: begin
				if (dsel_q == trs_pkg::DIV_FWD) begin
					state_d = trs_pkg::ST_WRITE;
				end else if (dsel_q == trs_pkg::DIV_THR) begin
					state_d = trs_pkg::ST_SCAN;
				end else begin
					state_d = (!mph_q && !ovf) ? trs_pkg::ST_MUL : trs_pkg::ST_CMP;
				end
			end
			trs_pkg::ST_CMP: state_d = more ? trs_pkg::ST_SCAN : trs_pkg::ST_FLUSH;
			trs_pkg::ST_FLUSH: state_d = trs_pkg::ST_IDLE;
			default: state_d = trs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= trs_pkg::ST_IDLE;
			act_q    <= '0;
			vld_q    <= '0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			if (state_q == trs_pkg::ST_IDLE && qh.valid &&
			    qh.op.kind == trs_pkg::OP_UPDATE) begin
				act_q[SW'(qh.op.base_sym)]  <= 1'b1;
				act_q[SW'(qh.op.quote_sym)] <= 1'b1;
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (state_q == trs_pkg::ST_MRES && dsel_q == trs_pkg::DIV_THR) begin
				pend_q <= 1'b0;
			end
			if (state_q == trs_pkg::ST_CMP && hit_now) begin
				strobe_q <= pend_q;
				pend_q   <= 1'b1;
			end
			if (state_q == trs_pkg::ST_FLUSH) begin
				strobe_q <= 1'b1;
				pend_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			trs_pkg::ST_IDLE: begin
				op_q   <= qh.op;
				rem_q  <= '0;
				quo_q  <= '0;
				dcnt_q <= '0;
				acc_q  <= '0;
				mk_q   <= '0;
				if (qh.op.kind == trs_pkg::OP_SCAN) begin
					dsel_q <= trs_pkg::DIV_THR;
					mx_q   <= 64'(min_return_ppm);
					my_q   <= trs_pkg::PPM_RECIP;
				end else if (qh.op.bid_price != '0) begin
					dsel_q <= trs_pkg::DIV_FWD;
					mx_q   <= 64'(qh.op.bid_price);
					my_q   <= trs_pkg::PPM_RECIP;
				end else begin
					dsel_q <= trs_pkg::DIV_REV;
					dvd_q  <= {trs_pkg::PPM_SCALE[31:0], 32'd0};
					dvs_q  <= qh.op.ask_price;
				end
			end
			trs_pkg::ST_DIV: begin
				dvd_q  <= {dvd_q[62:0], 1'b0};
				rem_q  <= rnext;
				quo_q  <= qnext;
				dcnt_q <= dcnt_q + 6'd1;
			end
			trs_pkg::ST_WRITE: begin
				dsel_q <= trs_pkg::DIV_REV;
				dvd_q  <= {trs_pkg::PPM_SCALE[31:0], 32'd0};
				dvs_q  <= op_q.ask_price;
				rem_q  <= '0;
				quo_q  <= '0;
				dcnt_q <= '0;
			end
			trs_pkg::ST_SCAN: begin
				rdv_q <= vld_q[raddr];
				if (!all_act) begin
					a_q <= na;
					b_q <= nb;
					c_q <= nc;
				end
			end
			trs_pkg::ST_RD_BC: begin
				rdv_q <= vld_q[raddr];
				rab_q <= rdval;
			end
			trs_pkg::ST_RD_CA: begin
				rdv_q <= vld_q[raddr];
				rbc_q <= rdval;
			end
			trs_pkg::ST_CAP: begin
				dsel_q <= trs_pkg::DIV_TRI;
				rca_q  <= rdval;
				mx_q   <= rab_q;
				my_q   <= rbc_q;
				mph_q  <= 1'b0;
				acc_q  <= '0;
				mk_q   <= '0;
			end
			trs_pkg::ST_MUL: begin
				if (mk_q != 3'd4) begin
					pp_s1 <= xp * yp;
					pk_s1 <= mk_q[1:0];
				end
				if (mk_q != 3'd0) begin
					unique case (pk_s1)
						2'd0: acc_q <= acc_q + 128'(pp_s1);
						2'd3: acc_q <= acc_q + {pp_s1, 64'd0};
						default: acc_q <= acc_q + {32'd0, pp_s1, 32'd0};
					endcase
				end
				mk_q <= mk_q + 3'd1;
			end
			trs_pkg::ST_MRES: begin
				if (dsel_q == trs_pkg::DIV_FWD) begin
					quo_q <= acc_q[109:46];
				end else if (dsel_q == trs_pkg::DIV_THR) begin
					thr_q <= 64'h1_0000_0000 + acc_q[109:46];
					a_q   <= SW'(0);
					b_q   <= SW'(1);
					c_q   <= SW'(2);
				end else if (!mph_q) begin
					if (ovf) begin
						f_q <= (rca_q == '0) ? '0 : '1;
					end else begin
						mx_q  <= acc_q[95:32];
						my_q  <= rca_q;
						mph_q <= 1'b1;
						acc_q <= '0;
						mk_q  <= '0;
					end
				end else begin
					f_q <= ovf ? '1 : acc_q[95:32];
				end
			end
			trs_pkg::ST_CMP: begin
				if (hit_now) begin
					result_q <= '{hit: 1'b1, first_sym: pa_q, second_sym: pb_q,
					              third_sym: pc_q, factor: pf_q, last: 1'b0};
					pa_q <= 3'(a_q);
					pb_q <= 3'(b_q);
					pc_q <= 3'(c_q);
					pf_q <= f_q;
				end
				a_q <= na;
				b_q <= nb;
				c_q <= nc;
			end
			trs_pkg::ST_FLUSH: begin
				if (pend_q) begin
					result_q <= '{hit: 1'b1, first_sym: pa_q, second_sym: pb_q,
					              third_sym: pc_q, factor: pf_q, last: 1'b1};
				end else begin
					result_q <= '{hit: 1'b0, first_sym: 3'd0, second_sym: 3'd0,
					              third_sym: 3'd0, factor: 64'd0, last: 1'b1};
				end
			end
			default: ;
		endcase
	end

	assign result = result_q;
	assign strobe = strobe_q;

endmodule
